/* rtl/ir_wfs_pkg.sv */
// Package for the IR wall-following steering unit.
// Holds the word and register types, register indexes, limits and polynomial tables.
// No dependencies.
package ir_wfs_pkg;

  localparam int ADC_BITS     = 10;
  localparam int SAMPLE_W     = ADC_BITS;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int QBITS        = 20;
  localparam int FRONT_MAX_CM = 130;
  localparam int SIDE_MAX_CM  = 70;

  typedef enum logic [2:0] {
    REG_WINDOW_COUNT = 3'd0,
    REG_CURVE_THRESH = 3'd1,
    REG_CURVE_GAIN   = 3'd2,
    REG_MIN_SPEED    = 3'd3,
    REG_MAX_CHANGE   = 3'd4,
    REG_CORR_DIVISOR = 3'd5
  } cfg_reg_e;

  localparam logic [7:0] WINDOW_COUNT_RST = 8'd31;
  localparam logic [6:0] CURVE_THRESH_RST = 7'd30;
  localparam logic [4:0] CURVE_GAIN_RST   = 5'd9;
  localparam logic [7:0] MIN_SPEED_RST    = 8'd100;
  localparam logic [7:0] MAX_CHANGE_RST   = 8'd150;
  localparam logic [9:0] CORR_DIVISOR_RST = 10'd50;

  typedef struct packed {
    logic [7:0] window_count;
    logic [6:0] curve_threshold_cm;
    logic [4:0] curve_gain;
    logic [7:0] min_speed;
    logic [7:0] max_change;
    logic [9:0] correction_divisor;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] front_sample;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic                start_press;
    logic                stop_press;
  } in_word_t;

  typedef struct packed {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [7:0] front_cm;
    logic [6:0] left_cm;
    logic [6:0] right_cm;
    logic       curve_mode;
    logic       running_flag;
  } out_word_t;

  typedef logic signed [63:0] coef_t;

  // Q20 coefficients, index [channel][power]; channels are front, left, right.
  localparam coef_t POLY [3][6] = '{
    '{ 64'sd342381377, -64'sd3753197973, 64'sd19190558870,
       -64'sd51200767811, 64'sd68476667899, -64'sd36420287686 },
    '{ 64'sd106881269, -64'sd1014428326, 64'sd4611150532,
       -64'sd11187597229, 64'sd13780068311, -64'sd6755217763 },
    '{ 64'sd124228521, -64'sd1235824226, 64'sd5734673511,
       -64'sd13978528572, 64'sd17177475224, -64'sd8379077818 }
  };

  // Base speed from the front distance: 100 + front * 155 / 130.
  function automatic logic [7:0] base_speed(input logic [7:0] front_cm);
    logic [15:0] scaled;
    scaled = (16'(front_cm) * 16'd155) / 16'd130;
    return 8'(16'd100 + scaled);
  endfunction

endpackage

/* rtl/ir_wfs_queue.sv */
// Small first-in first-out queue of flat words between the front and back ends.
// No package dependencies.
module ir_wfs_queue #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         valid_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/ir_wfs_div.sv */
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
module ir_wfs_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial  = {rem_q, quot_q[NUM_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quot_q <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CW'(NUM_W);
      end else if (cnt_q != '0) begin
        rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        quot_q <= {quot_q[NUM_W-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

endmodule

/* rtl/ir_wfs_front.sv */
// Front end: takes sample words, tracks run state and builds window totals.
// Depends on ir_wfs_pkg.
module ir_wfs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           window_count_i,
  input  logic                 push_i,
  input  ir_wfs_pkg::in_word_t in_i,
  output logic                 full_o,
  output logic                 job_push_o,
  output logic [3*(ir_wfs_pkg::ADC_BITS+8)+8:0] job_o,
  input  logic                 job_full_i
);
  localparam int TOTAL_W = ir_wfs_pkg::ADC_BITS + 8;

  typedef struct packed {
    logic               running;
    logic [7:0]         count;
    logic [TOTAL_W-1:0] right;
    logic [TOTAL_W-1:0] left;
    logic [TOTAL_W-1:0] front;
  } job_t;

  localparam logic [TOTAL_W-1:0] ADC_MASK = TOTAL_W'((1 << ir_wfs_pkg::ADC_BITS) - 1);

  logic [TOTAL_W-1:0] front_q, left_q, right_q;
  logic [TOTAL_W-1:0] front_d, left_d, right_d;
  logic [7:0]         count_q, count_d, win;
  logic               running_q, running_d, accept, window_end;
  job_t               job;

  assign accept     = push_i && !job_full_i;
  assign full_o     = job_full_i;
  assign win        = (window_count_i == '0) ? 8'd1 : window_count_i;

  always_comb begin
    running_d = in_i.stop_press ? 1'b0 : (in_i.start_press ? 1'b1 : running_q);
    front_d   = front_q + (TOTAL_W'(in_i.front_sample) & ADC_MASK);
    left_d    = left_q + (TOTAL_W'(in_i.left_sample) & ADC_MASK);
    right_d   = right_q + (TOTAL_W'(in_i.right_sample) & ADC_MASK);
    count_d   = count_q + 8'd1;
    window_end = (count_d >= win);
    job.running = running_d;
    job.count   = count_d;
    job.right   = right_d;
    job.left    = left_d;
    job.front   = front_d;
  end

  assign job_push_o = accept && window_end;
  assign job_o      = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      left_q    <= '0;
      right_q   <= '0;
      count_q   <= '0;
      running_q <= 1'b0;
    end else if (accept) begin
      running_q <= running_d;
      if (window_end) begin
        front_q <= '0;
        left_q  <= '0;
        right_q <= '0;
        count_q <= '0;
      end else begin
        front_q <= front_d;
        left_q  <= left_d;
        right_q <= right_d;
        count_q <= count_d;
      end
    end
  end

endmodule

/* rtl/ir_wfs_back.sv */
// Back end: averages, distance polynomials, steering and the result register.
// Depends on ir_wfs_pkg and ir_wfs_div.
module ir_wfs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ir_wfs_pkg::cfg_t      cfg_i,
  input  logic                  job_valid_i,
  input  logic [3*(ir_wfs_pkg::ADC_BITS+8)+8:0] job_i,
  output logic                  job_pop_o,
  output ir_wfs_pkg::out_word_t out_o,
  output logic                  empty_o,
  input  logic                  pop_i
);
  localparam int TOTAL_W   = ir_wfs_pkg::ADC_BITS + 8;
  localparam int DIV_W     = (TOTAL_W > 18) ? TOTAL_W : 18;
  localparam int NORM_UP   = (ir_wfs_pkg::ADC_BITS < 10) ? 10 - ir_wfs_pkg::ADC_BITS : 0;
  localparam int NORM_DOWN = (ir_wfs_pkg::ADC_BITS > 10) ? ir_wfs_pkg::ADC_BITS - 10 : 0;
  localparam int SHIFT     = 2 - NORM_UP + NORM_DOWN;

  typedef struct packed {
    logic               running;
    logic [7:0]         count;
    logic [TOTAL_W-1:0] right;
    logic [TOTAL_W-1:0] left;
    logic [TOTAL_W-1:0] front;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_MUL, S_ACC, S_CM, S_BASE, S_PREP, S_SDIV, S_DRIVE
  } state_e;

  state_e                state_q;
  job_t                  job_q;
  logic [1:0]            ch_q;
  logic [2:0]            k_q;
  logic [9:0]            x_q, absd_q;
  logic signed [63:0]    p_q;
  logic [41:0]           lo_q;
  logic signed [42:0]    hi_q;
  logic [7:0]            fcm_q, base_q;
  logic [6:0]            lcm_q, rcm_q;
  logic                  curve_q, neg_q, sat_q;
  ir_wfs_pkg::out_word_t out_q;
  logic                  out_valid_q;

  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_num, div_quot;
  logic [9:0]            div_den, div_rem, corr_div;
  logic [TOTAL_W-1:0]    chan_total;

  ir_wfs_div #(.NUM_W(DIV_W), .DEN_W(10)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign corr_div  = (cfg_i.correction_divisor == '0) ? 10'd1 : cfg_i.correction_divisor;
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_comb begin
    unique case (ch_q)
      2'd1:    chan_total = job_q.left;
      2'd2:    chan_total = job_q.right;
      default: chan_total = job_q.front;
    endcase
    div_start = (state_q == S_START) ||
                ((state_q == S_PREP) && job_q.running && !curve_q && !sat_q);
    if (state_q == S_PREP) begin
      div_num = DIV_W'(absd_q) * DIV_W'(cfg_i.max_change);
      div_den = corr_div;
    end else begin
      div_num = DIV_W'(chan_total);
      div_den = {2'b00, job_q.count};
    end
  end

  // Horner step: full product of p and x, divided by 1024 toward zero, plus coefficient.
  logic signed [74:0]    prod, prod_sh;
  logic signed [63:0]    p_next;
  logic [TOTAL_W+1:0]    avg_ext;
  logic [7:0]            cm_val, cm_max;
  always_comb begin
    prod    = $signed({hi_q, 32'b0}) + $signed({33'b0, lo_q});
    prod_sh = prod >>> 10;
    p_next  = prod_sh[63:0] + 64'(prod[74] && (prod[9:0] != '0))
              + ir_wfs_pkg::POLY[ch_q][k_q];
    avg_ext = {div_quot[TOTAL_W-1:0], 2'b00};
    cm_max  = (ch_q == 2'd0) ? 8'(ir_wfs_pkg::FRONT_MAX_CM) : 8'(ir_wfs_pkg::SIDE_MAX_CM);
    if (p_q[63]) begin
      cm_val = '0;
    end else if (p_q[62:ir_wfs_pkg::QBITS] > 43'(cm_max)) begin
      cm_val = cm_max;
    end else begin
      cm_val = p_q[ir_wfs_pkg::QBITS+7:ir_wfs_pkg::QBITS];
    end
  end

  // Steering decision inputs.
  logic signed [TOTAL_W:0] side_diff;
  logic [TOTAL_W-1:0]      side_abs;
  always_comb begin
    side_diff = $signed({1'b0, job_q.right}) - $signed({1'b0, job_q.left});
    side_abs  = side_diff[TOTAL_W] ? TOTAL_W'(-side_diff) : side_diff[TOTAL_W-1:0];
  end

  // Drive values.
  logic signed [7:0]  dcm;
  logic [6:0]         dcm_abs;
  logic [11:0]        gd;
  logic signed [13:0] trim;
  logic [7:0]         curve_trim;
  logic signed [9:0]  mc, qv, up, dn;
  logic signed [10:0] lsum, rsum;
  logic [7:0]         ld, rd;
  logic               rnz;
  always_comb begin
    dcm        = $signed({1'b0, lcm_q}) - $signed({1'b0, rcm_q});
    dcm_abs    = dcm[7] ? 7'(-dcm) : dcm[6:0];
    gd         = 12'(cfg_i.curve_gain) * 12'(dcm_abs);
    trim       = $signed({6'b0, base_q}) - $signed({2'b0, gd});
    curve_trim = trim[13] ? 8'd0 : trim[7:0];
    mc         = $signed({2'b0, cfg_i.max_change});
    qv         = $signed({2'b0, div_quot[7:0]});
    rnz        = (div_rem != '0);
    if (sat_q) begin
      up = neg_q ? -mc : mc;
      dn = -up;
    end else if (neg_q) begin
      up = -qv - 10'(rnz);
      dn = qv;
    end else begin
      up = qv;
      dn = -qv - 10'(rnz);
    end
    lsum = $signed({3'b0, base_q}) + 11'(up);
    rsum = $signed({3'b0, base_q}) + 11'(dn);
    ld   = '0;
    rd   = '0;
    if (job_q.running) begin
      if (curve_q) begin
        ld = (dcm < 0) ? curve_trim : base_q;
        rd = (dcm > 0) ? curve_trim : base_q;
      end else begin
        ld = (lsum < $signed({3'b0, cfg_i.min_speed})) ? cfg_i.min_speed :
             (lsum > 11'sd255) ? 8'd255 : lsum[7:0];
        rd = (rsum < $signed({3'b0, cfg_i.min_speed})) ? cfg_i.min_speed :
             (rsum > 11'sd255) ? 8'd255 : rsum[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      ch_q        <= '0;
      k_q         <= '0;
      x_q         <= '0;
      absd_q      <= '0;
      p_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      fcm_q       <= '0;
      lcm_q       <= '0;
      rcm_q       <= '0;
      base_q      <= '0;
      curve_q     <= 1'b0;
      neg_q       <= 1'b0;
      sat_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            ch_q    <= 2'd0;
            state_q <= S_START;
          end
        end
        S_START: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            x_q     <= 10'(avg_ext >> SHIFT);
            p_q     <= ir_wfs_pkg::POLY[ch_q][5];
            k_q     <= 3'd4;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          lo_q    <= p_q[31:0] * x_q;
          hi_q    <= $signed(p_q[63:32]) * $signed({1'b0, x_q});
          state_q <= S_ACC;
        end
        S_ACC: begin
          p_q <= p_next;
          if (k_q == '0) begin
            state_q <= S_CM;
          end else begin
            k_q     <= k_q - 3'd1;
            state_q <= S_MUL;
          end
        end
        S_CM: begin
          unique case (ch_q)
            2'd1:    lcm_q <= cm_val[6:0];
            2'd2:    rcm_q <= cm_val[6:0];
            default: fcm_q <= cm_val;
          endcase
          if (ch_q == 2'd2) begin
            state_q <= S_BASE;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_START;
          end
        end
        S_BASE: begin
          base_q  <= ir_wfs_pkg::base_speed(fcm_q);
          curve_q <= job_q.running && (lcm_q > cfg_i.curve_threshold_cm) &&
                     (rcm_q > cfg_i.curve_threshold_cm);
          neg_q   <= side_diff[TOTAL_W];
          sat_q   <= (side_abs >= TOTAL_W'(corr_div));
          absd_q  <= side_abs[9:0];
          state_q <= S_PREP;
        end
        S_PREP: state_q <= div_start ? S_SDIV : S_DRIVE;
        S_SDIV: begin
          if (div_done) begin
            state_q <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          if (!out_valid_q) begin
            out_q.left_drive   <= ld;
            out_q.right_drive  <= rd;
            out_q.front_cm     <= fcm_q;
            out_q.left_cm      <= lcm_q;
            out_q.right_cm     <= rcm_q;
            out_q.curve_mode   <= curve_q;
            out_q.running_flag <= job_q.running;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.running_flag) |->
      (out_q.left_drive == 8'd0 && out_q.right_drive == 8'd0 && !out_q.curve_mode))
    else $error("stopped result carries drive");
  a_drive_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRIVE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished word not registered");
  a_curve_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.curve_mode) |->
      (out_q.left_cm > cfg_i.curve_threshold_cm && out_q.right_cm > cfg_i.curve_threshold_cm))
    else $error("curve mode with a near side");
`endif

endmodule

/* rtl/ir_wall_follow_steering_unit.sv */
// Top level of the IR wall-following steering unit: register port and the two ends.
// Depends on ir_wfs_pkg, ir_wfs_front, ir_wfs_queue and ir_wfs_back.
//
//   Channel   Handshake            Payload
//   input     push / full          in_word_i  (three samples, start and stop presses)
//   result    empty / pop          out_word_o (drives, distances, mode, run flag)
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// A sample word is taken whenever full is low; full rises only while both window jobs are queued.
// Each window end runs the back end through the shared one-bit-per-cycle divider, for the
// three averages and for the straight correction division when it is not skipped, and
// through the split 64-bit Horner multiply.
// Reset clears the totals, the run state, the queue and the result register.
// A result that is not popped holds the back end, and the front end stalls once the
// queue between them has filled.
module ir_wall_follow_steering_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  ir_wfs_pkg::in_word_t                in_word_i,
  output logic                                empty,
  input  logic                                pop,
  output ir_wfs_pkg::out_word_t               out_word_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ir_wfs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ir_wfs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ir_wfs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  localparam int JOB_W = 3 * (ir_wfs_pkg::ADC_BITS + 8) + 9;

  ir_wfs_pkg::cfg_t cfg_q;
  logic             cfg_write;
  logic [2:0]       reg_idx;

  // Register file. Writes land in the access phase; pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_count       <= ir_wfs_pkg::WINDOW_COUNT_RST;
      cfg_q.curve_threshold_cm <= ir_wfs_pkg::CURVE_THRESH_RST;
      cfg_q.curve_gain         <= ir_wfs_pkg::CURVE_GAIN_RST;
      cfg_q.min_speed          <= ir_wfs_pkg::MIN_SPEED_RST;
      cfg_q.max_change         <= ir_wfs_pkg::MAX_CHANGE_RST;
      cfg_q.correction_divisor <= ir_wfs_pkg::CORR_DIVISOR_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ir_wfs_pkg::REG_WINDOW_COUNT: cfg_q.window_count       <= pwdata[7:0];
        ir_wfs_pkg::REG_CURVE_THRESH: cfg_q.curve_threshold_cm <= pwdata[6:0];
        ir_wfs_pkg::REG_CURVE_GAIN:   cfg_q.curve_gain         <= pwdata[4:0];
        ir_wfs_pkg::REG_MIN_SPEED:    cfg_q.min_speed          <= pwdata[7:0];
        ir_wfs_pkg::REG_MAX_CHANGE:   cfg_q.max_change         <= pwdata[7:0];
        ir_wfs_pkg::REG_CORR_DIVISOR: cfg_q.correction_divisor <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register selected by the address; unused addresses read zero.
  always_comb begin
    unique case (reg_idx)
      ir_wfs_pkg::REG_WINDOW_COUNT: prdata = 32'(cfg_q.window_count);
      ir_wfs_pkg::REG_CURVE_THRESH: prdata = 32'(cfg_q.curve_threshold_cm);
      ir_wfs_pkg::REG_CURVE_GAIN:   prdata = 32'(cfg_q.curve_gain);
      ir_wfs_pkg::REG_MIN_SPEED:    prdata = 32'(cfg_q.min_speed);
      ir_wfs_pkg::REG_MAX_CHANGE:   prdata = 32'(cfg_q.max_change);
      ir_wfs_pkg::REG_CORR_DIVISOR: prdata = 32'(cfg_q.correction_divisor);
      default:                      prdata = '0;
    endcase
  end

  // Window jobs travel from the front end to the back end through a two-entry queue.
  logic             job_push, job_full, job_valid, job_pop;
  logic [JOB_W-1:0] job_in, job_out;

  ir_wfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_count_i(cfg_q.window_count),
    .push_i        (push),
    .in_i          (in_word_i),
    .full_o        (full),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .job_full_i    (job_full)
  );

  ir_wfs_queue #(.W(JOB_W), .DEPTH(2)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .valid_o(job_valid)
  );

  ir_wfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .out_o      (out_word_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

/* tb/tb.sv */
// Testbench for the IR wall-following steering unit: a directed table, then random phases.
// Each word is checked against an in-bench model or a typed expectation. Depends on ir_wfs_pkg and the RTL top.
`timescale 1ns / 100ps

module tb;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  ir_wfs_pkg::in_word_t in_word_i = '0;
  logic empty;
  logic pop = 1'b0;
  ir_wfs_pkg::out_word_t out_word_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ir_wfs_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [ir_wfs_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [ir_wfs_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ir_wall_follow_steering_unit u_top (
    .clk_i, .rst_ni, .push, .full, .in_word_i, .empty, .pop, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's registers and its window state.
  ir_wfs_pkg::cfg_t shadow_cfg;
  int unsigned sum_front, sum_left, sum_right;
  logic [7:0]  window_fill;
  bit          motors_on;

  ir_wfs_pkg::out_word_t pending_words[$];
  int          fail_count = 0;
  bit          hold_req = 1'b0;
  bit          pop_burst = 1'b0;
  bit          push_burst = 1'b0;

  // Fifth-order Horner evaluation in Q20, truncated, then clamped in centimetres.
  function automatic int unsigned sample_to_cm(logic [9:0] avg, int ch, int maxcm);
    logic signed [63:0] acc;
    logic signed [63:0] xs;
    xs  = $signed({54'd0, avg});
    acc = ir_wfs_pkg::POLY[ch][5];
    for (int k = 4; k >= 0; k--) acc = (acc * xs) / 64'sd1024 + ir_wfs_pkg::POLY[ch][k];
    if (acc < 0) return 0;
    acc = acc >>> ir_wfs_pkg::QBITS;
    return (acc > maxcm) ? maxcm : int'(acc);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // Advances the window state by one accepted word; returns 1 when a window closes.
  function automatic bit steer_step(ir_wfs_pkg::in_word_t w,
                                    output ir_wfs_pkg::out_word_t res);
    int unsigned win;
    longint fcm, lcm, rcm, base, ld, rd, dlt, dv, mc, up, dn;
    bit curve;
    win = (shadow_cfg.window_count == 0) ? 1 : shadow_cfg.window_count;
    ld = 0;
    rd = 0;
    curve = 1'b0;
    if (w.stop_press) motors_on = 1'b0;
    else if (w.start_press) motors_on = 1'b1;
    sum_front += w.front_sample;
    sum_left  += w.left_sample;
    sum_right += w.right_sample;
    window_fill = window_fill + 8'd1;
    res = '0;
    if (window_fill < win) return 1'b0;
    fcm = sample_to_cm(10'(sum_front / window_fill), 0, ir_wfs_pkg::FRONT_MAX_CM);
    lcm = sample_to_cm(10'(sum_left / window_fill), 1, ir_wfs_pkg::SIDE_MAX_CM);
    rcm = sample_to_cm(10'(sum_right / window_fill), 2, ir_wfs_pkg::SIDE_MAX_CM);
    base = 100 + fcm * 155 / 130;
    if (motors_on) begin
      if (lcm > shadow_cfg.curve_threshold_cm && rcm > shadow_cfg.curve_threshold_cm) begin
        // Curve steering slows the side facing the nearer wall.
        dlt = lcm - rcm;
        curve = 1'b1;
        ld = base;
        rd = base;
        if (dlt > 0) rd = base - longint'(shadow_cfg.curve_gain) * dlt;
        else if (dlt < 0) ld = base + longint'(shadow_cfg.curve_gain) * dlt;
        ld = clip(ld, 0, 255);
        rd = clip(rd, 0, 255);
      end else begin
        dv  = (shadow_cfg.correction_divisor == 0) ? 1 : shadow_cfg.correction_divisor;
        dlt = longint'(sum_right) - longint'(sum_left);
        mc  = shadow_cfg.max_change;
        if (dlt >= dv) begin
          up = mc;
          dn = -mc;
        end else if (dlt <= -dv) begin
          up = -mc;
          dn = mc;
        end else begin
          up = div_floor(dlt * mc, dv);
          dn = div_floor(-dlt * mc, dv);
        end
        ld = clip(base + up, shadow_cfg.min_speed, 255);
        rd = clip(base + dn, shadow_cfg.min_speed, 255);
      end
    end
    res.left_drive   = 8'(ld);
    res.right_drive  = 8'(rd);
    res.front_cm     = 8'(fcm);
    res.left_cm      = 7'(lcm);
    res.right_cm     = 7'(rcm);
    res.curve_mode   = curve;
    res.running_flag = motors_on;
    sum_front = 0;
    sum_left  = 0;
    sum_right = 0;
    window_fill = '0;
    return 1'b1;
  endfunction

  task automatic reg_write(ir_wfs_pkg::cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ir_wfs_pkg::CFG_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ir_wfs_pkg::REG_WINDOW_COUNT: shadow_cfg.window_count       = 8'(value);
      ir_wfs_pkg::REG_CURVE_THRESH: shadow_cfg.curve_threshold_cm = 7'(value);
      ir_wfs_pkg::REG_CURVE_GAIN:   shadow_cfg.curve_gain         = 5'(value);
      ir_wfs_pkg::REG_MIN_SPEED:    shadow_cfg.min_speed          = 8'(value);
      ir_wfs_pkg::REG_MAX_CHANGE:   shadow_cfg.max_change         = 8'(value);
      default:                      shadow_cfg.correction_divisor = 10'(value);
    endcase
  endtask

  // Configuration is changed only once the block has drained.
  task automatic settle_then_config(int unsigned vals[6]);
    wait (pending_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 6; i++) reg_write(ir_wfs_pkg::cfg_reg_e'(i), vals[i]);
  endtask

  // Offers one word and waits for its acceptance. A typed expectation, when given,
  // replaces the modeled one in the store while the model still advances.
  task automatic send_word(ir_wfs_pkg::in_word_t w, bit typed,
                           ir_wfs_pkg::out_word_t typed_res);
    ir_wfs_pkg::out_word_t res;
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(posedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    if (steer_step(w, res)) pending_words.push_back(typed ? typed_res : res);
    push <= 1'b0;
  endtask

  function automatic ir_wfs_pkg::in_word_t random_word(int style);
    ir_wfs_pkg::in_word_t w;
    case (style)
      0: begin
        w.front_sample = 10'($urandom_range(0, 1023));
        w.left_sample  = 10'($urandom_range(0, 1023));
        w.right_sample = 10'($urandom_range(0, 1023));
      end
      1: begin  // open corridor: both sides far, so curves show up
        w.front_sample = 10'($urandom_range(0, 1023));
        w.left_sample  = 10'($urandom_range(0, 200));
        w.right_sample = 10'($urandom_range(0, 200));
      end
      default: begin
        w.front_sample = ($urandom_range(0, 1)) ? 10'd1023 : 10'd0;
        w.left_sample  = ($urandom_range(0, 1)) ? 10'd1023 : 10'($urandom_range(0, 1023));
        w.right_sample = ($urandom_range(0, 1)) ? 10'd0 : 10'($urandom_range(0, 1023));
      end
    endcase
    w.start_press = ($urandom_range(0, 7) == 0);
    w.stop_press  = ($urandom_range(0, 24) == 0);
    return w;
  endfunction

  typedef struct {
    ir_wfs_pkg::in_word_t  word;
    bit                    typed;
    ir_wfs_pkg::out_word_t res;
  } table_row_t;

  // Result checker and receive side: random pop gaps, one long hold on request.
  int  pop_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    ir_wfs_pkg::out_word_t want;
    int d;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: %p", out_word_o);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_word_o.left_drive !== want.left_drive) begin
            $error("left_drive: expected %0d, got %0d", want.left_drive, out_word_o.left_drive);
            fail_count++;
          end
          if (out_word_o.right_drive !== want.right_drive) begin
            $error("right_drive: expected %0d, got %0d", want.right_drive,
                   out_word_o.right_drive);
            fail_count++;
          end
          if (out_word_o.front_cm !== want.front_cm) begin
            $error("front_cm: expected %0d, got %0d", want.front_cm, out_word_o.front_cm);
            fail_count++;
          end
          if (out_word_o.left_cm !== want.left_cm) begin
            $error("left_cm: expected %0d, got %0d", want.left_cm, out_word_o.left_cm);
            fail_count++;
          end
          if (out_word_o.right_cm !== want.right_cm) begin
            $error("right_cm: expected %0d, got %0d", want.right_cm, out_word_o.right_cm);
            fail_count++;
          end
          if (out_word_o.curve_mode !== want.curve_mode) begin
            $error("curve_mode: expected %0d, got %0d", want.curve_mode, out_word_o.curve_mode);
            fail_count++;
          end
          if (out_word_o.running_flag !== want.running_flag) begin
            $error("running_flag: expected %0d, got %0d", want.running_flag,
                   out_word_o.running_flag);
            fail_count++;
          end
        end
        d = pop_burst ? 0 : $urandom_range(0, 5);
        pop_wait <= (d > 0) ? d - 1 : 0;
        pop      <= (d == 0);
      end else if (hold_req && !hold_done) begin
        // Long hold: the queue fills and the input side must stall.
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pop       <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait <= pop_wait - 1;
        pop      <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    table_row_t  rows[$];
    table_row_t  r;
    int unsigned phase_cfg[6];
    int          n_items;
    int          style;

    shadow_cfg = '{window_count: ir_wfs_pkg::WINDOW_COUNT_RST,
                   curve_threshold_cm: ir_wfs_pkg::CURVE_THRESH_RST,
                   curve_gain: ir_wfs_pkg::CURVE_GAIN_RST,
                   min_speed: ir_wfs_pkg::MIN_SPEED_RST,
                   max_change: ir_wfs_pkg::MAX_CHANGE_RST,
                   correction_divisor: ir_wfs_pkg::CORR_DIVISOR_RST};
    sum_front = 0;
    sum_left  = 0;
    sum_right = 0;
    window_fill = '0;
    motors_on = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: one word per window so every row yields a result.
    // Zero samples read as the far limit on all channels, so curve mode at full base speed.
    rows = '{
      '{'{10'd0, 10'd0, 10'd0, 1'b1, 1'b0}, 1'b1, '{8'd255, 8'd255, 8'd130, 7'd70, 7'd70,
                                                    1'b1, 1'b1}},
      '{'{10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd0, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd1023, 10'd0, 10'd1023, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd300, 10'd50, 10'd400, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd300, 10'd400, 10'd50, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd512, 10'd600, 10'd610, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd512, 10'd600, 10'd630, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd512, 10'd700, 10'd680, 1'b0, 1'b0}, 1'b0, '0},
      // Both presses together: stop wins, drives drop to zero.
      '{'{10'd0, 10'd0, 10'd0, 1'b1, 1'b1}, 1'b1, '{8'd0, 8'd0, 8'd130, 7'd70, 7'd70,
                                                    1'b0, 1'b0}},
      '{'{10'd1023, 10'd1023, 10'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'd0, 10'd0, 10'd0, 1'b1, 1'b0}, 1'b1, '{8'd255, 8'd255, 8'd130, 7'd70, 7'd70,
                                                    1'b1, 1'b1}},
      '{'{10'h2AA, 10'h155, 10'h2AA, 1'b0, 1'b0}, 1'b0, '0},
      '{'{10'h155, 10'h2AA, 10'h155, 1'b0, 1'b0}, 1'b0, '0}
    };
    phase_cfg = '{1, ir_wfs_pkg::CURVE_THRESH_RST, ir_wfs_pkg::CURVE_GAIN_RST,
                  ir_wfs_pkg::MIN_SPEED_RST, ir_wfs_pkg::MAX_CHANGE_RST,
                  ir_wfs_pkg::CORR_DIVISOR_RST};
    settle_then_config(phase_cfg);
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].res);

    // Random phases. Word counts that are not a multiple of the window leave windows partly
    // full across a config change, which also covers a window shrunk under a partial count.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: phase_cfg = '{1, 30, 9, 100, 150, 50};
        1: phase_cfg = '{0, 0, 0, 0, 0, 0};
        2: phase_cfg = '{255, 70, 31, 255, 255, 1023};
        3: phase_cfg = '{3, 40, 20, 50, 200, 300};
        4: phase_cfg = '{2, 10, 31, 0, 255, 1};
        default: phase_cfg = '{$urandom_range(1, 6), $urandom_range(0, 70),
                               $urandom_range(0, 31), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(1, 1023)};
      endcase
      settle_then_config(phase_cfg);
      n_items = (ph == 2) ? 260 : 37;
      push_burst = (ph % 3 == 0);
      pop_burst  = (ph % 4 == 1);
      for (int i = 0; i < n_items; i++) begin
        if (ph == 0 && i == 5) hold_req = 1'b1;
        if (ph == 0 && i < 40) push_burst = 1'b1;
        style = $urandom_range(0, 4);
        r.word = random_word(style < 2 ? 0 : (style < 4 ? 1 : 2));
        send_word(r.word, 1'b0, '0);
      end
    end

    wait (pending_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
